// ===== rtl/core/ffha_pkg.sv =====
// shared types, codes and defaults of the first-fit heap allocator
package ffha_pkg;

  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEAP_BYTES_DEF   = 1048576;
  localparam int HEADER_BYTES_DEF = 16;

  localparam int ADDR_W = 21;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;

  localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RESIZE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_ARRAY  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd2;
  localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MUL,
    S_SUM,
    S_LK_RD,
    S_LK_CHK,
    S_FIT_RD,
    S_FIT_CHK,
    S_APPEND,
    S_REL,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_REQ_ADDR,
    SRC_RD_START,
    SRC_BRK
  } res_src_t;

  typedef struct packed {
    logic             load_req;
    logic             mul;
    logic             sz_size;
    logic             sz_prod;
    logic             scan_clr;
    logic             scan_inc;
    logic             rd_en;
    logic             lk_hit;
    logic             fit_hit;
    logic             append;
    logic             release_blk;
    logic             res_en;
    logic [STAT_W-1:0] res_status;
    res_src_t         res_src;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             size_zero;
    logic             count_zero;
    logic             addr_zero;
    logic             scan_end;
    logic             lk_match;
    logic             fit_match;
    logic             fits_old;
    logic             append_ok;
    logic             prod_over;
  } stat_t;

endpackage

// ===== rtl/core/ffha_ctrl.sv =====
// request sequencer of the first-fit heap allocator
module ffha_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  ffha_pkg::stat_t st,
  output ffha_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            out_valid
);

  ffha_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffha_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    logic post_rel;
    post_rel  = (st.req_type == ffha_pkg::REQ_RESIZE) && !st.addr_zero;
    state_nxt = state_r;
    cmd       = '0;
    cmd.res_src    = ffha_pkg::SRC_ZERO;
    cmd.res_status = ffha_pkg::ST_OK;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ffha_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load_req = 1'b1;
          state_nxt    = ffha_pkg::S_DISPATCH;
        end
      end
      ffha_pkg::S_DISPATCH: begin
        case (st.req_type)
          ffha_pkg::REQ_ALLOC: begin
            if (st.size_zero) begin
              cmd.res_en = 1'b1; cmd.res_status = ffha_pkg::ST_NULL;
              state_nxt  = ffha_pkg::S_DONE;
            end else begin
              cmd.sz_size = 1'b1; cmd.scan_clr = 1'b1;
              state_nxt   = ffha_pkg::S_FIT_RD;
            end
          end
          ffha_pkg::REQ_FREE: begin
            if (st.addr_zero) begin
              cmd.res_en = 1'b1; cmd.res_status = ffha_pkg::ST_NULL;
              state_nxt  = ffha_pkg::S_DONE;
            end else begin
              cmd.scan_clr = 1'b1;
              state_nxt    = ffha_pkg::S_LK_RD;
            end
          end
          ffha_pkg::REQ_RESIZE: begin
            if (st.size_zero) begin
              cmd.res_en = 1'b1; cmd.res_status = ffha_pkg::ST_NULL;
              state_nxt  = ffha_pkg::S_DONE;
            end else if (st.addr_zero) begin
              cmd.sz_size = 1'b1; cmd.scan_clr = 1'b1;
              state_nxt   = ffha_pkg::S_FIT_RD;
            end else begin
              cmd.scan_clr = 1'b1;
              state_nxt    = ffha_pkg::S_LK_RD;
            end
          end
          default: begin
            if (st.size_zero || st.count_zero) begin
              cmd.res_en = 1'b1; cmd.res_status = ffha_pkg::ST_NULL;
              state_nxt  = ffha_pkg::S_DONE;
            end else begin
              cmd.mul   = 1'b1;
              state_nxt = ffha_pkg::S_MUL;
            end
          end
        endcase
      end
      ffha_pkg::S_MUL: begin
        state_nxt = ffha_pkg::S_SUM;
      end
      ffha_pkg::S_SUM: begin
        if (st.prod_over) begin
          cmd.res_en = 1'b1; cmd.res_status = ffha_pkg::ST_NOSPACE;
          state_nxt  = ffha_pkg::S_DONE;
        end else begin
          cmd.sz_prod = 1'b1; cmd.scan_clr = 1'b1;
          state_nxt   = ffha_pkg::S_FIT_RD;
        end
      end
      ffha_pkg::S_LK_RD: begin
        if (st.scan_end) begin
          cmd.res_en = 1'b1; cmd.res_status = ffha_pkg::ST_UNKNOWN;
          state_nxt  = ffha_pkg::S_DONE;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = ffha_pkg::S_LK_CHK;
        end
      end
      ffha_pkg::S_LK_CHK: begin
        if (st.lk_match) begin
          cmd.lk_hit = 1'b1;
          if (st.req_type == ffha_pkg::REQ_FREE) begin
            state_nxt = ffha_pkg::S_REL;
          end else if (st.fits_old) begin
            cmd.res_en  = 1'b1;
            cmd.res_src = ffha_pkg::SRC_REQ_ADDR;
            state_nxt   = ffha_pkg::S_DONE;
          end else begin
            cmd.sz_size = 1'b1; cmd.scan_clr = 1'b1;
            state_nxt   = ffha_pkg::S_FIT_RD;
          end
        end else begin
          cmd.scan_inc = 1'b1;
          state_nxt    = ffha_pkg::S_LK_RD;
        end
      end
      ffha_pkg::S_FIT_RD: begin
        if (st.scan_end) begin
          state_nxt = ffha_pkg::S_APPEND;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = ffha_pkg::S_FIT_CHK;
        end
      end
      ffha_pkg::S_FIT_CHK: begin
        if (st.fit_match) begin
          cmd.fit_hit = 1'b1;
          cmd.res_en  = 1'b1;
          cmd.res_src = ffha_pkg::SRC_RD_START;
          state_nxt   = post_rel ? ffha_pkg::S_REL : ffha_pkg::S_DONE;
        end else begin
          cmd.scan_inc = 1'b1;
          state_nxt    = ffha_pkg::S_FIT_RD;
        end
      end
      ffha_pkg::S_APPEND: begin
        if (st.append_ok) begin
          cmd.append  = 1'b1;
          cmd.res_en  = 1'b1;
          cmd.res_src = ffha_pkg::SRC_BRK;
          state_nxt   = post_rel ? ffha_pkg::S_REL : ffha_pkg::S_DONE;
        end else begin
          cmd.res_en = 1'b1; cmd.res_status = ffha_pkg::ST_NOSPACE;
          state_nxt  = ffha_pkg::S_DONE;
        end
      end
      ffha_pkg::S_REL: begin
        cmd.release_blk = 1'b1;
        if (st.req_type == ffha_pkg::REQ_FREE) begin
          cmd.res_en = 1'b1;
        end
        state_nxt = ffha_pkg::S_DONE;
      end
      ffha_pkg::S_DONE: begin
        out_valid = 1'b1;
        state_nxt = ffha_pkg::S_IDLE;
      end
      default: begin
        state_nxt = ffha_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/ffha_dpath.sv =====
// block table, break pointer, scan counter and result registers
module ffha_dpath #(
  parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ffha_pkg::cmd_t                  cmd,
  output ffha_pkg::stat_t                 st,
  input  logic [ffha_pkg::REQ_W-1:0]      in_req_type,
  input  logic [ffha_pkg::ADDR_W-1:0]     in_size,
  input  logic [ffha_pkg::ADDR_W-1:0]     in_count,
  input  logic [ffha_pkg::ADDR_W-1:0]     in_address,
  output logic [ffha_pkg::ADDR_W-1:0]     out_result_address,
  output logic [ffha_pkg::STAT_W-1:0]     out_status
);

  localparam int AW   = $clog2(HEAP_BYTES + 1);
  localparam int IW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNTW = $clog2(MAX_BLOCKS + 1);
  localparam int SZW  = (AW > ffha_pkg::ADDR_W) ? AW : ffha_pkg::ADDR_W;
  localparam int CW   = SZW + 1;
  localparam int EW   = SZW + 2;
  localparam int LOW  = 11;
  localparam int HIW  = ffha_pkg::ADDR_W - LOW;
  localparam int PW   = 2 * ffha_pkg::ADDR_W;

  // block table
  logic [AW-1:0] mem_start [MAX_BLOCKS];
  logic [AW-1:0] mem_size  [MAX_BLOCKS];
  logic          mem_free  [MAX_BLOCKS];

  logic [AW-1:0] rd_start_r, rd_size_r;
  logic          rd_free_r;

  logic [CNTW-1:0] cnt_r, scan_r, old_idx_r;
  logic [AW-1:0]   brk_r, old_start_r;
  logic [SZW-1:0]  sz_r;

  logic [ffha_pkg::REQ_W-1:0]  req_type_r;
  logic [ffha_pkg::ADDR_W-1:0] req_size_r, req_count_r, req_addr_r;
  logic [ffha_pkg::ADDR_W+LOW-1:0] lo_r;
  logic [ffha_pkg::ADDR_W+HIW-1:0] hi_r;
  logic [ffha_pkg::ADDR_W-1:0] res_addr_r;
  logic [ffha_pkg::STAT_W-1:0] res_stat_r;

  logic [PW-1:0]  prod;
  logic [CW-1:0]  rd_payload, brk_payload;
  logic [EW-1:0]  brk_end;
  logic           is_last;

  assign prod        = PW'({hi_r, {LOW{1'b0}}}) + PW'(lo_r);
  assign rd_payload  = CW'(rd_start_r) + CW'(HEADER_BYTES);
  assign brk_payload = CW'(brk_r) + CW'(HEADER_BYTES);
  assign brk_end     = EW'(brk_r) + EW'(HEADER_BYTES) + EW'(sz_r);
  assign is_last     = (old_idx_r + CNTW'(1)) == cnt_r;

  always_comb begin
    st            = '0;
    st.req_type   = req_type_r;
    st.size_zero  = (req_size_r == '0);
    st.count_zero = (req_count_r == '0);
    st.addr_zero  = (req_addr_r == '0);
    st.scan_end   = (scan_r >= cnt_r);
    st.lk_match   = (rd_payload == CW'(req_addr_r));
    st.fit_match  = rd_free_r && (SZW'(rd_size_r) >= sz_r);
    st.fits_old   = (SZW'(rd_size_r) >= SZW'(req_size_r));
    st.append_ok  = (cnt_r < CNTW'(MAX_BLOCKS)) && (brk_end <= EW'(HEAP_BYTES));
    st.prod_over  = (prod > PW'(HEAP_BYTES));
  end

  // table write and registered read
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem_start[cnt_r[IW-1:0]] <= brk_r;
      mem_size[cnt_r[IW-1:0]]  <= sz_r[AW-1:0];
      mem_free[cnt_r[IW-1:0]]  <= 1'b0;
    end else if (cmd.fit_hit) begin
      mem_free[scan_r[IW-1:0]] <= 1'b0;
    end else if (cmd.release_blk && !is_last) begin
      mem_free[old_idx_r[IW-1:0]] <= 1'b1;
    end
    if (cmd.rd_en) begin
      rd_start_r <= mem_start[scan_r[IW-1:0]];
      rd_size_r  <= mem_size[scan_r[IW-1:0]];
      rd_free_r  <= mem_free[scan_r[IW-1:0]];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      brk_r <= '0;
    end else if (cmd.append) begin
      cnt_r <= cnt_r + CNTW'(1);
      brk_r <= brk_end[AW-1:0];
    end else if (cmd.release_blk && is_last) begin
      cnt_r <= cnt_r - CNTW'(1);
      brk_r <= old_start_r;
    end
  end

  // request, scan and result registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_type_r  <= in_req_type;
      req_size_r  <= in_size;
      req_count_r <= in_count;
      req_addr_r  <= in_address;
    end
    if (cmd.mul) begin
      lo_r <= req_count_r * req_size_r[LOW-1:0];
      hi_r <= req_count_r * req_size_r[ffha_pkg::ADDR_W-1:LOW];
    end
    if (cmd.sz_size) begin
      sz_r <= SZW'(req_size_r);
    end else if (cmd.sz_prod) begin
      sz_r <= prod[SZW-1:0];
    end
    if (cmd.scan_clr) begin
      scan_r <= '0;
    end else if (cmd.scan_inc) begin
      scan_r <= scan_r + CNTW'(1);
    end
    if (cmd.lk_hit) begin
      old_idx_r   <= scan_r;
      old_start_r <= rd_start_r;
    end
    if (cmd.res_en) begin
      res_stat_r <= cmd.res_status;
      case (cmd.res_src)
        ffha_pkg::SRC_REQ_ADDR: res_addr_r <= req_addr_r;
        ffha_pkg::SRC_RD_START: res_addr_r <= rd_payload[ffha_pkg::ADDR_W-1:0];
        ffha_pkg::SRC_BRK:      res_addr_r <= brk_payload[ffha_pkg::ADDR_W-1:0];
        default:                res_addr_r <= '0;
      endcase
    end
  end

  assign out_result_address = res_addr_r;
  assign out_status         = res_stat_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(MAX_BLOCKS))
    else $error("block count above table depth");

  a_brk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    brk_r <= AW'(HEAP_BYTES))
    else $error("break beyond heap end");

  a_empty_brk: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (brk_r == '0))
    else $error("empty table with nonzero break");

  a_rel_idx: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.release_blk |-> (old_idx_r < cnt_r))
    else $error("release of an entry past the table end");

endmodule

// ===== rtl/core/first_fit_heap_allocator_core.sv =====
// top level of the first-fit heap allocator: sequencer plus table datapath
//
// channel   ports                                       handshake
// request   in_req_type in_size in_count in_address     start & !busy
// result    out_result_address out_status               out_valid, one cycle
//
// lookup and first-fit scans read the table one entry at a time
// (registered table read, then compare), a resize that moves runs a
// lookup scan up to the match and then a first-fit scan, array requests
// add a registered multiply and overflow check before the first-fit scan
// reset is synchronous active low; it empties the table and zeroes the break,
// the table memory itself is not cleared
// busy stays high from the accepted beat until the result beat; the result
// receiver cannot stall, out_valid lasts exactly one cycle
module first_fit_heap_allocator_core #(
  parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ffha_pkg::REQ_W-1:0]  in_req_type,
  input  logic [ffha_pkg::ADDR_W-1:0] in_size,
  input  logic [ffha_pkg::ADDR_W-1:0] in_count,
  input  logic [ffha_pkg::ADDR_W-1:0] in_address,
  output logic                        out_valid,
  output logic [ffha_pkg::ADDR_W-1:0] out_result_address,
  output logic [ffha_pkg::STAT_W-1:0] out_status
);

  // command and status between sequencer and datapath
  ffha_pkg::cmd_t  cmd;
  ffha_pkg::stat_t st;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .st        (st),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // table, break pointer and result registers
  ffha_dpath #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_req_type        (in_req_type),
    .in_size            (in_size),
    .in_count           (in_count),
    .in_address         (in_address),
    .out_result_address (out_result_address),
    .out_status         (out_status)
  );

endmodule
